[rtl/core/wat_pkg.sv]
// shared types and constants of the weekday alarm table
package wat_pkg;

  localparam int unsigned ALARM_SLOTS_DEF = 8;
  localparam int unsigned MAX_FIRES       = 8;
  localparam int unsigned FIRE_CNT_W      = $clog2(MAX_FIRES + 1);

  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINUTE_MAX = 8'd59;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_CANCEL = 3'd3,
    REQ_ENABLE = 3'd4,
    REQ_READ   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARG  = 2'd1,
    ST_INACTIVE = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_RESP,
    S_TICK_END
  } state_e;

  typedef struct packed {
    logic       active;
    logic       enabled;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] days;
    logic       fire_vld;
    logic [4:0] fire_hour;
    logic [5:0] fire_minute;
    logic [2:0] fire_wday;
  } alarm_entry_t;

endpackage

[rtl/core/weekday_alarm_table.sv]
// weekday alarm table: slot memory, request sequencer and output register
//
// Alarms live in a single-port-read, single-port-write slot memory with a
// registered read, so the sequencer looks at one slot per cycle unless the
// output side stalls. A create or a time tick walks the slots from the
// lowest. Update, cancel, set enable and read visit only the named slot, and
// rejected requests and ticks that repeat an already checked minute read no
// slot. A tick gives one word per fired slot (at most 8, the last flagged by
// tlast) or a single word with fired low; every other request gives one word.
// The slot memory needs no clearing pass: per-slot valid bits make
// never-written slots read as inactive.
module weekday_alarm_table #(
  parameter int unsigned ALARM_SLOTS = wat_pkg::ALARM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[3:0] alarm_hour[11:4] alarm_minute[19:12] day_mask[27:20]
  // enable_flag[28] now_hour[33:29] now_minute[39:34] now_weekday[42:40]
  // time_valid[43], zero fill [47:44]
  input  logic [47:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_id[3:0] entry_active[4] entry_enabled[5] entry_hour[10:6]
  // entry_minute[16:11] entry_days[23:17]
  output logic [23:0] m_axis_tdata,
  // status[1:0] fired[2]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned AddrW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(ALARM_SLOTS - 1);
  localparam logic [4:0] SlotLimit = 5'(ALARM_SLOTS);
  localparam logic [wat_pkg::FIRE_CNT_W-1:0] FireCap =
    wat_pkg::FIRE_CNT_W'(wat_pkg::MAX_FIRES);

  // input word fields
  logic [3:0] in_slot;
  logic [7:0] in_ahour, in_amin, in_mask;
  logic       in_en, in_tv;
  logic [4:0] in_nhour;
  logic [5:0] in_nmin;
  logic [2:0] in_wday;
  logic [2:0] in_req;

  assign in_slot  = s_axis_tdata[3:0];
  assign in_ahour = s_axis_tdata[11:4];
  assign in_amin  = s_axis_tdata[19:12];
  assign in_mask  = s_axis_tdata[27:20];
  assign in_en    = s_axis_tdata[28];
  assign in_nhour = s_axis_tdata[33:29];
  assign in_nmin  = s_axis_tdata[39:34];
  assign in_wday  = s_axis_tdata[42:40];
  assign in_tv    = s_axis_tdata[43];
  assign in_req   = s_axis_tuser;

  // control state
  wat_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [wat_pkg::FIRE_CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic pend_vld_q, pend_vld_d;
  logic [AddrW-1:0] pend_slot_q, pend_slot_d;
  logic capped_q, capped_d;
  logic chk_vld_q, chk_vld_d;
  logic [10:0] last_min_q, last_min_d;
  wat_pkg::status_e res_status_q, res_status_d;
  logic [3:0] res_slot_q, res_slot_d;

  // request registers
  logic [2:0] req_q;
  logic [3:0] slot_q;
  logic [4:0] ahour_q;
  logic [5:0] amin_q;
  logic [6:0] mask_q;
  logic       en_q;
  logic [4:0] nhour_q;
  logic [5:0] nmin_q;
  logic [2:0] wday_q;
  logic       accept;

  // slot memory
  wat_pkg::alarm_entry_t ent_mem_q [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] ent_vld_q;
  wat_pkg::alarm_entry_t rd_q;
  logic rd_vld_q;
  logic mem_re, mem_we;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  wat_pkg::alarm_entry_t mem_wdata;
  wat_pkg::alarm_entry_t cur_ent;

  // output register
  logic out_vld_q, out_load, out_free;
  logic [1:0]  out_status_q, out_status_d;
  logic        out_fired_q, out_fired_d;
  logic        out_last_q, out_last_d;
  logic [23:0] out_data_q, out_data_d;

  logic [10:0] cur_min, in_cur_min;
  logic        in_args_ok, in_slot_ok;
  logic        hit, last_slot;
  logic [7:0]  days_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign cur_ent  = rd_vld_q ? rd_q : '0;
  assign last_slot = (idx_q == LastIdx);

  // hour*60 + minute as shift and subtract
  assign in_cur_min = {in_nhour, 6'b0} - {4'b0, in_nhour, 2'b0} + {5'b0, in_nmin};
  assign cur_min    = {nhour_q, 6'b0} - {4'b0, nhour_q, 2'b0} + {5'b0, nmin_q};

  assign in_args_ok = (in_ahour <= wat_pkg::HOUR_MAX) && (in_amin <= wat_pkg::MINUTE_MAX)
                      && !in_mask[7];
  assign in_slot_ok = ({1'b0, in_slot} < SlotLimit);

  // weekday 7 indexes the zero fill and matches no nonzero mask
  assign days_ext = {1'b0, cur_ent.days};
  assign hit = cur_ent.active && cur_ent.enabled
               && (cur_ent.hour == nhour_q) && (cur_ent.minute == nmin_q)
               && ((cur_ent.days == '0) || days_ext[wday_q])
               && !(cur_ent.fire_vld && (cur_ent.fire_hour == nhour_q)
                    && (cur_ent.fire_minute == nmin_q) && (cur_ent.fire_wday == wday_q));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    fire_cnt_d   = fire_cnt_q;
    pend_vld_d   = pend_vld_q;
    pend_slot_d  = pend_slot_q;
    capped_d     = capped_q;
    chk_vld_d    = chk_vld_q;
    last_min_d   = last_min_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    s_axis_tready = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = cur_ent;
    out_load     = 1'b0;
    out_status_d = wat_pkg::ST_OK;
    out_fired_d  = 1'b0;
    out_last_d   = 1'b1;
    out_data_d   = '0;

    unique case (state_q)
      wat_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          idx_d      = '0;
          fire_cnt_d = '0;
          pend_vld_d = 1'b0;
          capped_d   = 1'b0;
          res_status_d = wat_pkg::ST_BAD_ARG;
          res_slot_d   = in_slot;
          state_d      = wat_pkg::S_RESP;
          unique case (in_req)
            wat_pkg::REQ_TICK: begin
              res_status_d = wat_pkg::ST_OK;
              res_slot_d   = '0;
              if (in_tv && !(chk_vld_q && (last_min_q == in_cur_min))) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = wat_pkg::S_SCAN;
              end
            end
            wat_pkg::REQ_CREATE: begin
              res_slot_d = '0;
              if (in_args_ok) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = wat_pkg::S_SCAN;
              end
            end
            wat_pkg::REQ_UPDATE, wat_pkg::REQ_CANCEL,
            wat_pkg::REQ_ENABLE, wat_pkg::REQ_READ: begin
              if (in_slot_ok && ((in_req != wat_pkg::REQ_UPDATE) || in_args_ok)) begin
                mem_re    = 1'b1;
                mem_raddr = in_slot[AddrW-1:0];
                state_d   = wat_pkg::S_SLOT;
              end
            end
            default: ;
          endcase
        end
      end

      wat_pkg::S_SCAN: begin
        if (req_q == wat_pkg::REQ_TICK) begin
          if (hit && (fire_cnt_q == FireCap)) begin
            capped_d = 1'b1;
            state_d  = wat_pkg::S_TICK_END;
          end else if (!(hit && pend_vld_q && !out_free)) begin
            if (hit) begin
              mem_we                = 1'b1;
              mem_wdata.fire_vld    = 1'b1;
              mem_wdata.fire_hour   = nhour_q;
              mem_wdata.fire_minute = nmin_q;
              mem_wdata.fire_wday   = wday_q;
              // one-shot alarm retires on firing
              if (cur_ent.days == '0) mem_wdata.active = 1'b0;
              if (pend_vld_q) begin
                out_load    = 1'b1;
                out_fired_d = 1'b1;
                out_last_d  = 1'b0;
                out_data_d[3:0] = 4'(pend_slot_q);
              end
              pend_vld_d  = 1'b1;
              pend_slot_d = idx_q;
              fire_cnt_d  = fire_cnt_q + 1'b1;
            end
            if (last_slot) begin
              state_d = wat_pkg::S_TICK_END;
            end else begin
              idx_d     = idx_q + AddrW'(1);
              mem_re    = 1'b1;
              mem_raddr = idx_q + AddrW'(1);
            end
          end
        end else begin
          // create: first inactive slot wins
          if (!cur_ent.active) begin
            if (out_free) begin
              mem_we    = 1'b1;
              mem_wdata = '{active: 1'b1, enabled: en_q, hour: ahour_q, minute: amin_q,
                            days: mask_q, default: '0};
              out_load  = 1'b1;
              out_data_d[3:0] = 4'(idx_q);
              state_d   = wat_pkg::S_IDLE;
            end
          end else if (last_slot) begin
            res_status_d = wat_pkg::ST_FULL;
            res_slot_d   = '0;
            state_d      = wat_pkg::S_RESP;
          end else begin
            idx_d     = idx_q + AddrW'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_q + AddrW'(1);
          end
        end
      end

      wat_pkg::S_SLOT: begin
        mem_waddr = slot_q[AddrW-1:0];
        if (out_free) begin
          out_load        = 1'b1;
          out_data_d[3:0] = slot_q;
          state_d         = wat_pkg::S_IDLE;
          if (req_q == wat_pkg::REQ_READ) begin
            out_data_d[23:4] = {cur_ent.days, cur_ent.minute, cur_ent.hour,
                                cur_ent.enabled, cur_ent.active};
          end else if (!cur_ent.active) begin
            out_status_d = wat_pkg::ST_INACTIVE;
          end else begin
            mem_we = 1'b1;
            unique case (req_q)
              wat_pkg::REQ_UPDATE: begin
                mem_wdata.hour        = ahour_q;
                mem_wdata.minute      = amin_q;
                mem_wdata.days        = mask_q;
                mem_wdata.fire_vld    = 1'b0;
                mem_wdata.fire_hour   = '0;
                mem_wdata.fire_minute = '0;
                mem_wdata.fire_wday   = '0;
              end
              wat_pkg::REQ_CANCEL: mem_wdata.active  = 1'b0;
              default:             mem_wdata.enabled = en_q;
            endcase
          end
        end
      end

      wat_pkg::S_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_d    = res_status_q;
          out_data_d[3:0] = res_slot_q;
          state_d         = wat_pkg::S_IDLE;
        end
      end

      wat_pkg::S_TICK_END: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_fired_d = pend_vld_q;
          out_data_d[3:0] = pend_vld_q ? 4'(pend_slot_q) : 4'b0;
          // a capped scan leaves the minute open for a repeat tick
          if (!capped_q) begin
            chk_vld_d  = 1'b1;
            last_min_d = cur_min;
          end
          state_d = wat_pkg::S_IDLE;
        end
      end

      default: state_d = wat_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wat_pkg::S_IDLE;
      idx_q        <= '0;
      fire_cnt_q   <= '0;
      pend_vld_q   <= 1'b0;
      pend_slot_q  <= '0;
      capped_q     <= 1'b0;
      chk_vld_q    <= 1'b0;
      last_min_q   <= '0;
      res_status_q <= wat_pkg::ST_OK;
      res_slot_q   <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_vld_q   <= pend_vld_d;
      pend_slot_q  <= pend_slot_d;
      capped_q     <= capped_d;
      chk_vld_q    <= chk_vld_d;
      last_min_q   <= last_min_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // request and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= in_req;
      slot_q  <= in_slot;
      ahour_q <= in_ahour[4:0];
      amin_q  <= in_amin[5:0];
      mask_q  <= in_mask[6:0];
      en_q    <= in_en;
      nhour_q <= in_nhour;
      nmin_q  <= in_nmin;
      wday_q  <= in_wday;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_fired_q  <= out_fired_d;
      out_last_q   <= out_last_d;
      out_data_q   <= out_data_d;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) ent_mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= ent_mem_q[mem_raddr];
  end

  // written-once bits so untouched slots read as all zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) ent_vld_q[mem_waddr] <= 1'b1;
      if (mem_re) rd_vld_q <= ent_vld_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_fired_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != wat_pkg::S_IDLE))
    else $error("accepted word did not start work");

  a_write_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == wat_pkg::S_SCAN) || (state_q == wat_pkg::S_SLOT)))
    else $error("slot memory written outside a slot visit");

  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= FireCap)
    else $error("fire count beyond limit");

  a_pend_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && (state_q != wat_pkg::S_IDLE)) |-> (req_q == wat_pkg::REQ_TICK))
    else $error("pending fire outside a tick");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_fired_d) |-> (out_status_d == wat_pkg::ST_OK))
    else $error("fired word with error status");

endmodule
